// File: rtl/idll_pkg.sv
// package: constants, payload structs, opcodes, status codes and state encoding for the linked list core
package idll_pkg;

  localparam int Capacity  = 64;
  localparam int SlotBits  = $clog2(Capacity);
  localparam int CountBits = $clog2(Capacity + 1);
  localparam int ValueBits = 32;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_READ     = 3'd6,
    OP_NOP      = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [6:0]         position;
    logic signed [31:0] item_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [6:0]         element_count;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE_RD,
    S_WALK_RD,
    S_WALK,
    S_INS_A,
    S_INS_B,
    S_DEL_RD,
    S_DEL_A,
    S_DEL_B,
    S_READ_RD,
    S_READ_WAIT,
    S_DONE
  } state_t;

endpackage

// File: rtl/idll_ram.sv
// generic single-port-write, single-read ram with registered read data
module idll_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/idll_free_stack.sv
// free-slot stack: ram plus a fill mark so unwritten entries read as their own index
module idll_free_stack (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [idll_pkg::SlotBits-1:0]    push_addr,
  input  logic [idll_pkg::SlotBits-1:0]    push_slot,
  input  logic [idll_pkg::SlotBits-1:0]    raddr,
  output logic [idll_pkg::SlotBits-1:0]    rslot
);

  logic [idll_pkg::SlotBits-1:0] ram_q;
  logic [idll_pkg::SlotBits-1:0] raddr_q;
  logic [idll_pkg::Capacity-1:0] written;
  logic                          hit_q;

  idll_ram #(.Width(idll_pkg::SlotBits), .Depth(idll_pkg::Capacity)) u_ram (
    .clk  (clk),
    .we   (push),
    .waddr(push_addr),
    .wdata(push_slot),
    .raddr(raddr),
    .rdata(ram_q)
  );

  // entries never pushed since reset read as the index itself
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (push) begin
      written[push_addr] <= 1'b1;
    end
    raddr_q <= raddr;
    hit_q   <= written[raddr];
  end

  assign rslot = hit_q ? ram_q : raddr_q;

endmodule

// File: rtl/indexed_doubly_linked_list_core.sv
// top level: bounded doubly linked list controller with slot memories
// One request at a time. A request that fails its checks, or the unused opcode,
// goes from accept straight to the done state. Head and tail inserts go through
// the free slot read and two insert states, head and tail deletes through a link
// read and two delete states. An indexed insert, delete or read walks the links,
// from the head for positions in the lower half and from the tail otherwise.
// Each step is a link read and a move. The walk takes n steps, with n at most 31.
// The result word sits in an output register until taken, and the next request
// is accepted in the cycle after that word has been delivered. There is no
// clearing pass.
module indexed_doubly_linked_list_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  idll_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output idll_pkg::out_word_t out_data
);

  localparam int SB = idll_pkg::SlotBits;
  localparam int CB = idll_pkg::CountBits;
  localparam int VB = idll_pkg::ValueBits;

  idll_pkg::state_t state, state_next;

  logic [2:0]    op;
  logic [VB-1:0] val;
  logic [CB-1:0] count;
  logic [SB-1:0] head_slot, tail_slot;
  logic [SB-1:0] new_slot;   // slot taken for an insert
  logic [SB-1:0] cur;        // slot under the walk
  logic [CB-1:0] steps;      // remaining walk steps
  logic          fwd;
  logic [SB-1:0] a_slot, b_slot;

  // link rams: next and prev, value ram
  logic          nx_we, pv_we, vl_we;
  logic [SB-1:0] nx_wa, nx_wd, nx_ra, nx_rd;
  logic [SB-1:0] pv_wa, pv_wd, pv_ra, pv_rd;
  logic [SB-1:0] vl_wa, vl_ra;
  logic [VB-1:0] vl_rd;

  logic          fs_push;
  logic [SB-1:0] fs_addr, fs_slot, fs_raddr, fs_rslot;

  idll_ram #(.Width(SB), .Depth(idll_pkg::Capacity)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
  idll_ram #(.Width(SB), .Depth(idll_pkg::Capacity)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(pv_ra), .rdata(pv_rd));
  idll_ram #(.Width(VB), .Depth(idll_pkg::Capacity)) u_value (
    .clk(clk), .we(vl_we), .waddr(vl_wa), .wdata(val), .raddr(vl_ra), .rdata(vl_rd));

  idll_free_stack u_free (
    .clk(clk), .rst(rst), .push(fs_push), .push_addr(fs_addr), .push_slot(fs_slot),
    .raddr(fs_raddr), .rslot(fs_rslot));

  logic          accept;
  logic          is_ins, is_del;
  logic [CB-1:0] pos_c, half, lastpos;
  logic [1:0]    chk_st;
  logic          mid;        // indexed op that needs a walk
  logic [CB-1:0] walk_tgt;   // target position of the walk
  logic          walk_fwd;
  logic [CB-1:0] walk_n;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == idll_pkg::S_IDLE) && !out_valid;
  assign pos_c    = CB'(in_data.position);
  assign half     = count >> 1;
  assign lastpos  = count - CB'(1);
  assign is_ins   = in_data.opcode == idll_pkg::OP_INS_HEAD
                 || in_data.opcode == idll_pkg::OP_INS_TAIL
                 || in_data.opcode == idll_pkg::OP_INS_POS;
  assign is_del   = in_data.opcode == idll_pkg::OP_DEL_HEAD
                 || in_data.opcode == idll_pkg::OP_DEL_TAIL
                 || in_data.opcode == idll_pkg::OP_DEL_POS;

  always_comb begin
    chk_st = idll_pkg::ST_OK;
    if (is_ins) begin
      if (in_data.opcode == idll_pkg::OP_INS_POS && in_data.position > 7'(count)) begin
        chk_st = idll_pkg::ST_BADPOS;
      end else if (count == CB'(idll_pkg::Capacity)) begin
        chk_st = idll_pkg::ST_FULL;
      end
    end else if (is_del || in_data.opcode == idll_pkg::OP_READ) begin
      if (count == '0) begin
        chk_st = idll_pkg::ST_EMPTY;
      end else if ((in_data.opcode == idll_pkg::OP_DEL_POS
                    || in_data.opcode == idll_pkg::OP_READ)
                   && in_data.position >= 7'(count)) begin
        chk_st = idll_pkg::ST_BADPOS;
      end
    end
  end

  // walk target: insert at p links after p-1; delete/read find p
  always_comb begin
    mid = 1'b0;
    walk_tgt = pos_c;
    if (in_data.opcode == idll_pkg::OP_INS_POS) begin
      mid = count != '0 && pos_c != '0 && pos_c < count;
      walk_tgt = pos_c - CB'(1);
    end else if (in_data.opcode == idll_pkg::OP_DEL_POS) begin
      mid = pos_c != '0 && pos_c != lastpos;
    end else if (in_data.opcode == idll_pkg::OP_READ) begin
      mid = 1'b1;
    end
    walk_fwd = walk_tgt < half;
    walk_n   = walk_fwd ? walk_tgt : lastpos - walk_tgt;
  end

  // effective kind of an insert or delete: 0 head, 1 tail, 2 middle
  logic [1:0] kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= idll_pkg::S_IDLE;
      count     <= '0;
      head_slot <= '0;
      tail_slot <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        op  <= in_data.opcode;
        val <= in_data.item_value;
        fwd   <= walk_fwd;
        steps <= walk_n;
        cur   <= walk_fwd ? head_slot : tail_slot;
        out_data.read_value    <= (chk_st != idll_pkg::ST_OK
                                   && in_data.opcode == idll_pkg::OP_READ) ? '1 : '0;
        out_data.status        <= chk_st;
        out_data.element_count <= 7'(count);
        if (in_data.opcode == idll_pkg::OP_INS_HEAD || in_data.opcode == idll_pkg::OP_DEL_HEAD
            || (in_data.opcode == idll_pkg::OP_INS_POS && pos_c == '0)
            || (in_data.opcode == idll_pkg::OP_DEL_POS && pos_c == '0)) begin
          kind <= 2'd0;
        end else if (mid) begin
          kind <= 2'd2;
        end else begin
          kind <= 2'd1;
        end
      end
      unique case (state)
        idll_pkg::S_FREE_RD: begin
          new_slot <= fs_rslot;
        end
        idll_pkg::S_WALK: begin
          cur   <= fwd ? nx_rd : pv_rd;
          steps <= steps - CB'(1);
        end
        idll_pkg::S_INS_A: begin
          if (count == '0) begin
            head_slot <= new_slot;
            tail_slot <= new_slot;
          end else if (kind == 2'd0) begin
            head_slot <= new_slot;
          end else if (kind == 2'd1) begin
            tail_slot <= new_slot;
          end
          a_slot <= cur;
          b_slot <= nx_rd;
        end
        idll_pkg::S_INS_B: begin
          count <= count + CB'(1);
          out_data.element_count <= 7'(count + CB'(1));
        end
        idll_pkg::S_DEL_RD: begin
          // keep the slot being freed, head and tail move on in the next state
          cur <= del_slot;
        end
        idll_pkg::S_DEL_A: begin
          a_slot <= pv_rd;
          b_slot <= nx_rd;
          if (kind == 2'd0) begin
            if (count > CB'(1)) begin
              head_slot <= nx_rd;
            end
          end else if (kind == 2'd1 && count > CB'(1)) begin
            tail_slot <= pv_rd;
          end
        end
        idll_pkg::S_DEL_B: begin
          count <= count - CB'(1);
          out_data.element_count <= 7'(count - CB'(1));
        end
        idll_pkg::S_READ_WAIT: begin
          out_data.read_value <= vl_rd;
        end
        idll_pkg::S_DONE: begin
          out_valid <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      idll_pkg::S_IDLE: begin
        if (accept) begin
          if (chk_st != idll_pkg::ST_OK || in_data.opcode == idll_pkg::OP_NOP) begin
            state_next = idll_pkg::S_DONE;
          end else if (is_ins) begin
            state_next = idll_pkg::S_FREE_RD;
          end else begin
            state_next = mid ? idll_pkg::S_WALK_RD : idll_pkg::S_DEL_RD;
          end
        end
      end
      idll_pkg::S_FREE_RD:
        state_next = (kind == 2'd2) ? idll_pkg::S_WALK_RD : idll_pkg::S_INS_A;
      idll_pkg::S_WALK_RD:
        state_next = (steps == '0) ? (op == idll_pkg::OP_READ ? idll_pkg::S_READ_RD
                     : op == idll_pkg::OP_INS_POS ? idll_pkg::S_INS_A
                     : idll_pkg::S_DEL_A) : idll_pkg::S_WALK;
      idll_pkg::S_WALK:
        state_next = idll_pkg::S_WALK_RD;
      idll_pkg::S_INS_A:    state_next = idll_pkg::S_INS_B;
      idll_pkg::S_INS_B:    state_next = idll_pkg::S_DONE;
      idll_pkg::S_DEL_RD:   state_next = idll_pkg::S_DEL_A;
      idll_pkg::S_DEL_A:    state_next = idll_pkg::S_DEL_B;
      idll_pkg::S_DEL_B:    state_next = idll_pkg::S_DONE;
      idll_pkg::S_READ_RD:  state_next = idll_pkg::S_READ_WAIT;
      idll_pkg::S_READ_WAIT: state_next = idll_pkg::S_DONE;
      idll_pkg::S_DONE:     state_next = idll_pkg::S_IDLE;
      default:              state_next = idll_pkg::S_IDLE;
    endcase
  end

  // memory ports
  // S_WALK_RD issues read of cur; data arrives in the following state
  logic [SB-1:0] del_slot;
  assign del_slot = (kind == 2'd0) ? head_slot : (kind == 2'd1) ? tail_slot : cur;

  always_comb begin
    nx_we = 1'b0; nx_wa = new_slot; nx_wd = '0; nx_ra = cur;
    pv_we = 1'b0; pv_wa = new_slot; pv_wd = '0; pv_ra = cur;
    vl_we = 1'b0; vl_wa = new_slot; vl_ra = cur;
    fs_push = 1'b0; fs_addr = SB'(count - CB'(1)); fs_slot = cur;
    fs_raddr = SB'(count);
    unique case (state)
      idll_pkg::S_DEL_RD: begin
        nx_ra = del_slot;
        pv_ra = del_slot;
      end
      idll_pkg::S_INS_A: begin
        // cur data (next link of a) valid here for a middle insert
        vl_we = 1'b1;
        if (count != '0) begin
          if (kind == 2'd0) begin
            nx_we = 1'b1; nx_wa = new_slot; nx_wd = head_slot;
            pv_we = 1'b1; pv_wa = head_slot; pv_wd = new_slot;
          end else if (kind == 2'd1) begin
            pv_we = 1'b1; pv_wa = new_slot; pv_wd = tail_slot;
            nx_we = 1'b1; nx_wa = tail_slot; nx_wd = new_slot;
          end else begin
            pv_we = 1'b1; pv_wa = new_slot; pv_wd = cur;
            nx_we = 1'b1; nx_wa = new_slot; nx_wd = nx_rd;
          end
        end
      end
      idll_pkg::S_INS_B: begin
        if (kind == 2'd2 && count != '0) begin
          nx_we = 1'b1; nx_wa = a_slot; nx_wd = new_slot;
          pv_we = 1'b1; pv_wa = b_slot; pv_wd = new_slot;
        end
      end
      idll_pkg::S_DEL_B: begin
        fs_push = 1'b1;
        if (kind == 2'd2) begin
          nx_we = 1'b1; nx_wa = a_slot; nx_wd = b_slot;
          pv_we = 1'b1; pv_wa = b_slot; pv_wd = a_slot;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: verif/tb_indexed_doubly_linked_list_core.sv
// testbench: randomized request traffic for the linked list core, checked against a list model
`timescale 1ns / 100ps

class list_scoreboard;
  logic signed [31:0] elems[$];
  idll_pkg::out_word_t pending[$];
  int errors;
  int shown;

  function new();
    errors = 0;
    shown = 0;
  endfunction

  // list kept as a queue of values in order, head first
  function void note_request(idll_pkg::in_word_t w);
    idll_pkg::out_word_t r;
    int unsigned n;
    r = '0;
    n = elems.size();
    r.status = idll_pkg::ST_OK;
    case (idll_pkg::opcode_t'(w.opcode))
      idll_pkg::OP_INS_HEAD, idll_pkg::OP_INS_TAIL, idll_pkg::OP_INS_POS: begin
        if (w.opcode == idll_pkg::OP_INS_POS && w.position > n) r.status = idll_pkg::ST_BADPOS;
        else if (n >= idll_pkg::Capacity) r.status = idll_pkg::ST_FULL;
        else if (w.opcode == idll_pkg::OP_INS_HEAD) elems.push_front(w.item_value);
        else if (w.opcode == idll_pkg::OP_INS_TAIL) elems.push_back(w.item_value);
        else elems.insert(w.position, w.item_value);
      end
      idll_pkg::OP_DEL_HEAD, idll_pkg::OP_DEL_TAIL, idll_pkg::OP_DEL_POS: begin
        if (n == 0) r.status = idll_pkg::ST_EMPTY;
        else if (w.opcode == idll_pkg::OP_DEL_HEAD) elems.delete(0);
        else if (w.opcode == idll_pkg::OP_DEL_TAIL) elems.delete(n - 1);
        else if (w.position >= n) r.status = idll_pkg::ST_BADPOS;
        else elems.delete(w.position);
      end
      idll_pkg::OP_READ: begin
        if (n == 0) r.status = idll_pkg::ST_EMPTY;
        else if (w.position >= n) r.status = idll_pkg::ST_BADPOS;
        if (r.status == idll_pkg::ST_OK) r.read_value = elems[w.position];
        else r.read_value = -1;
      end
      default: ;
    endcase
    r.element_count = 7'(elems.size());
    pending.push_back(r);
  endfunction

  function void check_result(idll_pkg::out_word_t got);
    idll_pkg::out_word_t exp;
    if (pending.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("unexpected word %h", got);
      end
      return;
    end
    exp = pending.pop_front();
    if (got.read_value !== exp.read_value || got.status !== exp.status ||
        got.element_count !== exp.element_count) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("mismatch: exp value %0d status %0d count %0d, got value %0d status %0d count %0d",
                 exp.read_value, exp.status, exp.element_count,
                 got.read_value, got.status, got.element_count);
      end
    end
  endfunction
endclass

module tb_indexed_doubly_linked_list_core;

  localparam int CycleLimit = 1000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  idll_pkg::in_word_t in_data;
  logic out_valid;
  logic out_ready;
  idll_pkg::out_word_t out_data;

  list_scoreboard board;
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;

  indexed_doubly_linked_list_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
  end

  always @(posedge clk) begin
    if (rst) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
    end
    if (cycles > CycleLimit) begin
      $display("indexed_doubly_linked_list_core test failed");
      $finish;
    end
  end

  // receiver: random stall, check words on accept
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) board.check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays up after an accept until the next word or an idle cycle replaces it
  task automatic send_word(input int op, input int pos, input logic [31:0] val);
    idll_pkg::in_word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w.opcode = 3'(op);
    w.position = 7'(pos);
    w.item_value = val;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(w);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(3))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // mostly legal positions, sometimes at or just past the boundary
  function automatic int rand_pos(input int n, input bit ins);
    int r;
    r = $urandom_range(9);
    if (r == 0) return $urandom_range(127);
    if (r == 1) return n + 1;
    if (r == 2) return ins ? n : (n == 0 ? 0 : n - 1);
    return $urandom_range(ins ? n : (n == 0 ? 0 : n - 1));
  endfunction

  task automatic random_phase(input int items, input int idle, input int stall);
    int k;
    int n;
    int op;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (k = 0; k < items; k++) begin
      n = board.elems.size();
      op = $urandom_range(99);
      // bias toward filling when short and draining when long
      if (op < 40) op = (n < 48 || $urandom_range(1)) ? $urandom_range(2) : 3 + $urandom_range(2);
      else if (op < 60) op = (n > 16 || $urandom_range(1)) ? 3 + $urandom_range(2) : $urandom_range(2);
      else if (op < 95) op = idll_pkg::OP_READ;
      else op = idll_pkg::OP_NOP;
      send_word(op, rand_pos(n, op <= idll_pkg::OP_INS_POS), rand_value());
    end
  endtask

  initial begin
    int i;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list cases, then inserts, reads and deletes on a short list
    send_word(idll_pkg::OP_DEL_HEAD, 0, 0);
    send_word(idll_pkg::OP_DEL_TAIL, 0, 0);
    send_word(idll_pkg::OP_DEL_POS, 0, 0);
    send_word(idll_pkg::OP_READ, 0, 0);
    send_word(idll_pkg::OP_INS_POS, 1, 5);
    send_word(idll_pkg::OP_INS_POS, 0, 32'h8000_0000);
    send_word(idll_pkg::OP_INS_HEAD, 0, 32'h7fff_ffff);
    send_word(idll_pkg::OP_INS_TAIL, 127, 32'hffff_ffff);
    send_word(idll_pkg::OP_INS_POS, 3, 32'h1234_5678);
    send_word(idll_pkg::OP_INS_POS, 1, 32'h5555_aaaa);
    send_word(idll_pkg::OP_READ, 0, 0);
    send_word(idll_pkg::OP_READ, 3, 0);
    send_word(idll_pkg::OP_READ, 4, 0);
    send_word(idll_pkg::OP_READ, 127, 0);
    send_word(idll_pkg::OP_DEL_POS, 2, 0);
    send_word(idll_pkg::OP_DEL_POS, 3, 0);
    send_word(idll_pkg::OP_NOP, 127, 32'hffff_ffff);
    // fill to capacity, overflow, then read far end and empty out
    for (i = 0; i < 64; i++) send_word(idll_pkg::OP_INS_TAIL, 0, $urandom);
    send_word(idll_pkg::OP_INS_HEAD, 0, 1);
    send_word(idll_pkg::OP_INS_POS, 64, 1);
    send_word(idll_pkg::OP_READ, 63, 0);
    send_word(idll_pkg::OP_READ, 32, 0);
    send_word(idll_pkg::OP_DEL_POS, 63, 0);
    for (i = 0; i < 63; i++) begin
      send_word(i[0] ? idll_pkg::OP_DEL_HEAD : idll_pkg::OP_DEL_TAIL, 0, 0);
    end

    random_phase(215, 0, 0);
    random_phase(215, 69, 0);
    random_phase(215, 0, 69);
    random_phase(215, 37, 37);
    in_valid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("indexed_doubly_linked_list_core test passed");
    end else begin
      $display("indexed_doubly_linked_list_core test failed");
    end
    $finish;
  end
endmodule
